[rtl/core/clnw_pkg.sv]
// Shared types and constants of the character-LCD nibble writer.
package clnw_pkg;

  // Request codes on the command field.
  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GOTO = 2'd1,
    CMD_INIT = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ROW1_BASE    = 3'd0,
    REG_ROW2_BASE    = 3'd1,
    REG_ROW3_BASE    = 3'd2,
    REG_ROW4_BASE    = 3'd3,
    REG_DISPLAY_TYPE = 3'd4,
    REG_FOUR_ROWS    = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  // Control characters and controller commands.
  localparam logic [7:0] CH_FORM_FEED = 8'h0C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] LCD_CLEAR    = 8'h01;
  localparam logic [7:0] LCD_SET_ADDR = 8'h80;
  localparam logic [7:0] LCD_FUNC_SET = 8'h20;
  localparam logic [7:0] LCD_ENTRY    = 8'h06;
  localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;

  // Reset values of the configuration registers.
  localparam logic [6:0] ROW1_RST = 7'd0;
  localparam logic [6:0] ROW2_RST = 7'd64;
  localparam logic [6:0] ROW3_RST = 7'd20;
  localparam logic [6:0] ROW4_RST = 7'd84;
  localparam logic [1:0] DTYPE_RST = 2'd2;

  // Row numbers, counted from one.
  localparam logic [2:0] ROW_ONE   = 3'd1;
  localparam logic [2:0] ROW_TWO   = 3'd2;
  localparam logic [2:0] ROW_THREE = 3'd3;
  localparam logic [2:0] ROW_FOUR  = 3'd4;

  // Sequencer last step indexes.
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] BYTE_LAST_STEP = 4'd1;
  localparam logic [StepW-1:0] INIT_LAST_STEP = 4'd11;

  // Work queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_INIT = 1'b1
  } op_kind_e;

  // One unit of work for the back end: a byte or the start-up sequence.
  // For the start-up sequence data holds the function set command.
  typedef struct packed {
    op_kind_e   kind;
    logic       rs;
    logic [7:0] data;
    logic       lwait;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/core/clnw_front.sv]
// Front end: config registers, row tracking and request classification.
module clnw_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [clnw_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [clnw_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             push_i,
  input  logic [1:0]                       command_i,
  input  logic [7:0]                       char_code_i,
  input  logic [7:0]                       col_x_i,
  input  logic [7:0]                       row_y_i,
  input  clnw_pkg::q_status_t              q_status_i,
  output logic                             q_wr_o,
  output clnw_pkg::op_t                    q_op_o
);

  logic [6:0] row1_q, row2_q, row3_q, row4_q;
  logic [1:0] dtype_q;
  logic       four_rows_q;
  logic [2:0] row_q, row_d;

  logic       accept;
  logic [7:0] tgt_x, tgt_y;
  logic [6:0] base;
  logic [2:0] goto_row;
  logic [7:0] addr;

  assign accept = push_i && !q_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row1_q      <= clnw_pkg::ROW1_RST;
      row2_q      <= clnw_pkg::ROW2_RST;
      row3_q      <= clnw_pkg::ROW3_RST;
      row4_q      <= clnw_pkg::ROW4_RST;
      dtype_q     <= clnw_pkg::DTYPE_RST;
      four_rows_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clnw_pkg::REG_ROW1_BASE:    row1_q      <= cfg_wdata_i;
        clnw_pkg::REG_ROW2_BASE:    row2_q      <= cfg_wdata_i;
        clnw_pkg::REG_ROW3_BASE:    row3_q      <= cfg_wdata_i;
        clnw_pkg::REG_ROW4_BASE:    row4_q      <= cfg_wdata_i;
        clnw_pkg::REG_DISPLAY_TYPE: dtype_q     <= cfg_wdata_i[1:0];
        clnw_pkg::REG_FOUR_ROWS:    four_rows_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Newline is a goto to column one of the following row.
  always_comb begin
    if (command_i == clnw_pkg::CMD_PUT) begin
      tgt_x = 8'd1;
      tgt_y = {5'd0, row_q + 3'd1};
    end else begin
      tgt_x = col_x_i;
      tgt_y = row_y_i;
    end
  end

  always_comb begin
    if (tgt_y == 8'd2) begin
      base     = row2_q;
      goto_row = clnw_pkg::ROW_TWO;
    end else if (tgt_y == 8'd3 && four_rows_q) begin
      base     = row3_q;
      goto_row = clnw_pkg::ROW_THREE;
    end else if (tgt_y == 8'd4 && four_rows_q) begin
      base     = row4_q;
      goto_row = clnw_pkg::ROW_FOUR;
    end else begin
      base     = row1_q;
      goto_row = clnw_pkg::ROW_ONE;
    end
  end

  // base + x - 1, wrapping at 256
  assign addr = {1'b0, base} + tgt_x + 8'hFF;

  always_comb begin
    q_wr_o       = 1'b0;
    q_op_o.kind  = clnw_pkg::OP_BYTE;
    q_op_o.rs    = 1'b0;
    q_op_o.data  = clnw_pkg::LCD_SET_ADDR | addr;
    q_op_o.lwait = 1'b0;
    row_d        = row_q;
    unique case (command_i)
      clnw_pkg::CMD_PUT: begin
        q_wr_o = accept;
        if (char_code_i == clnw_pkg::CH_FORM_FEED) begin
          q_op_o.data  = clnw_pkg::LCD_CLEAR;
          q_op_o.lwait = 1'b1;
          row_d        = clnw_pkg::ROW_ONE;
        end else if (char_code_i == clnw_pkg::CH_NEWLINE) begin
          row_d = goto_row;
        end else begin
          q_op_o.rs   = 1'b1;
          q_op_o.data = char_code_i;
        end
      end
      clnw_pkg::CMD_GOTO: begin
        q_wr_o = accept;
        row_d  = goto_row;
      end
      clnw_pkg::CMD_INIT: begin
        q_wr_o      = accept;
        q_op_o.kind = clnw_pkg::OP_INIT;
        q_op_o.data = clnw_pkg::LCD_FUNC_SET | {4'd0, dtype_q, 2'd0};
        row_d       = clnw_pkg::ROW_ONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= clnw_pkg::ROW_ONE;
    end else if (accept) begin
      row_q <= row_d;
    end
  end

endmodule

[rtl/core/clnw_queue.sv]
// Short work queue between the front and back ends.
module clnw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  clnw_pkg::op_t       wr_op_i,
  input  logic                rd_i,
  output clnw_pkg::op_t       rd_op_o,
  output clnw_pkg::q_status_t status_o
);

  clnw_pkg::op_t             mem_q [clnw_pkg::QDepth];
  logic [clnw_pkg::QAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [clnw_pkg::QAw:0]    cnt_q;

  assign status_o.full  = (cnt_q == (clnw_pkg::QAw+1)'(clnw_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign rd_op_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/clnw_back.sv]
// Back end: steps through each unit of work, one nibble per cycle unless output waits.
module clnw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clnw_pkg::q_status_t q_status_i,
  input  clnw_pkg::op_t       q_op_i,
  output logic                q_rd_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic                reg_select_o,
  output logic [3:0]          nibble_o,
  output logic                long_wait_o,
  output logic                last_o
);

  clnw_pkg::op_t                 cur_q;
  logic                          cur_vld_q;
  logic [clnw_pkg::StepW-1:0]    step_q;
  logic                          out_vld_q;

  logic                          emit, fin;
  logic [3:0]                    nib;
  logic                          nib_wait;

  assign emit   = cur_vld_q && (!out_vld_q || pop_i);
  assign fin    = (cur_q.kind == clnw_pkg::OP_INIT) ? (step_q == clnw_pkg::INIT_LAST_STEP)
                                                    : (step_q == clnw_pkg::BYTE_LAST_STEP);
  assign q_rd_o = !q_status_i.empty && (!cur_vld_q || (emit && fin));
  assign empty_o = !out_vld_q;

  // Nibble for the current step.
  always_comb begin
    nib      = cur_q.data[7:4];
    nib_wait = 1'b0;
    if (cur_q.kind == clnw_pkg::OP_BYTE) begin
      if (step_q[0]) begin
        nib      = cur_q.data[3:0];
        nib_wait = cur_q.lwait;
      end
    end else begin
      case (step_q)
        4'd0, 4'd1, 4'd2: begin
          nib      = clnw_pkg::NIB_WAKE;
          nib_wait = 1'b1;
        end
        4'd3:  nib = clnw_pkg::NIB_4BIT;
        4'd4:  nib = cur_q.data[7:4];
        4'd5: begin
          nib      = cur_q.data[3:0];
          nib_wait = 1'b1;
        end
        4'd6:  nib = clnw_pkg::LCD_CLEAR[7:4];
        4'd7: begin
          nib      = clnw_pkg::LCD_CLEAR[3:0];
          nib_wait = 1'b1;
        end
        4'd8:  nib = clnw_pkg::LCD_ENTRY[7:4];
        4'd9:  nib = clnw_pkg::LCD_ENTRY[3:0];
        4'd10: nib = clnw_pkg::LCD_DISP_ON[7:4];
        default: nib = clnw_pkg::LCD_DISP_ON[3:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (q_rd_o) begin
        cur_vld_q <= 1'b1;
        step_q    <= '0;
      end else if (emit) begin
        if (fin) cur_vld_q <= 1'b0;
        step_q <= step_q + 1'b1;
      end
      if (emit)       out_vld_q <= 1'b1;
      else if (pop_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) cur_q <= q_op_i;
    if (emit) begin
      reg_select_o <= cur_q.rs;
      nibble_o     <= nib;
      long_wait_o  <= nib_wait;
      last_o       <= fin;
    end
  end

endmodule

[rtl/core/char_lcd_nibble_writer_unit.sv]
// Top level of the character-LCD nibble writer.
//
// Turns character-LCD requests into 4-bit bus transactions for a display
// controller of the common 44780 kind. Each result transaction is one
// enable pulse: register select, the nibble for D7..D4, a long-wait flag
// (about 2 ms must pass after the pulse) and a last flag on the final
// nibble of a request. Put char sends a data byte as two nibbles, high
// first; form feed sends the clear command and newline moves to column 1
// of the next row. Goto sends the set-address command, init sends the
// 12-nibble start-up sequence. Command code 3 is accepted and dropped.
// The back end emits one nibble per cycle unless an unpopped result holds
// it; the front end takes one request per cycle into a 4-entry work queue
// while that queue is not full, so requests keep flowing while results wait.
// With the back end idle, the first result of a request passes the work
// queue, the current-work register and the output register on its way to
// the result ports. Configuration registers are written through cfg_we_i
// and take effect for requests accepted afterwards; write them only while
// idle.
module char_lcd_nibble_writer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [clnw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [clnw_pkg::CfgDataW-1:0] cfg_wdata_i,
  // request side
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    char_code_i,
  input  logic [7:0]                    col_x_i,
  input  logic [7:0]                    row_y_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          reg_select_o,
  output logic [3:0]                    nibble_o,
  output logic                          long_wait_o,
  output logic                          last_o
);

  clnw_pkg::q_status_t q_status;
  clnw_pkg::op_t       wr_op, rd_op;
  logic                q_wr, q_rd;

  // Request side stalls only when the work queue is full.
  assign full = q_status.full;

  // Front end: classifies requests, resolves rows and addresses.
  clnw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .col_x_i     (col_x_i),
    .row_y_i     (row_y_i),
    .q_status_i  (q_status),
    .q_wr_o      (q_wr),
    .q_op_o      (wr_op)
  );

  // Work queue decouples the two sides.
  clnw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_op_i  (wr_op),
    .rd_i     (q_rd),
    .rd_op_o  (rd_op),
    .status_o (q_status)
  );

  // Back end: nibble sequencer with output register.
  clnw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .q_op_i       (rd_op),
    .q_rd_o       (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .reg_select_o (reg_select_o),
    .nibble_o     (nibble_o),
    .long_wait_o  (long_wait_o),
    .last_o       (last_o)
  );

endmodule

[rtl/core/clnw_checker.sv]
// Port-level checks of the nibble writer, bound to the top level.
module clnw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       reg_select_o,
  input logic [3:0] nibble_o,
  input logic       long_wait_o,
  input logic       last_o
);

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable({reg_select_o, nibble_o, long_wait_o, last_o})))
    else $error("result changed while waiting");

  // Data nibbles never ask for a long wait.
  a_data_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(reg_select_o && long_wait_o))
    else $error("long wait on a data nibble");

  // The high data nibble is always followed by the low data nibble.
  a_data_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && reg_select_o && !last_o) |=> (empty || (reg_select_o && last_o)))
    else $error("data byte split");

  // Leaving reset, no result is waiting.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty)
    else $error("result present after reset");

endmodule

bind char_lcd_nibble_writer_unit clnw_checker u_clnw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .reg_select_o (reg_select_o),
  .nibble_o     (nibble_o),
  .long_wait_o  (long_wait_o),
  .last_o       (last_o)
);
